// ===== hdl/wmep_pkg.sv =====
// Types, codes and lookup functions for the 802.11 management element parser.
// Used by wmep_core.sv and wlan_mgmt_element_parser.sv.
package wmep_pkg;

    localparam int unsigned C_FRAME_MAX = 4096;
    localparam int unsigned C_QDEPTH    = 4;

    typedef enum logic [3:0] {
        K_ASSOC     = 4'd0,
        K_DISASSOC  = 4'd1,
        K_DEAUTH    = 4'd2,
        K_BEACON    = 4'd3,
        K_PROBE     = 4'd4,
        K_PROBE_RSP = 4'd5,
        K_DATA      = 4'd6,
        K_IGNORED   = 4'd7,
        K_UNKNOWN   = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        PH_TAG  = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_VAL  = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_TAG_END = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    localparam logic [2:0] VC_NONE     = 3'd0;
    localparam logic [2:0] VC_KNOWN    = 3'd1;
    localparam logic [2:0] VC_MS_CIPH  = 3'd2;
    localparam logic [2:0] VC_MS_OTHER = 3'd3;
    localparam logic [2:0] VC_SILENT   = 3'd4;
    localparam logic [2:0] VC_UNKNOWN  = 3'd5;
    localparam logic [2:0] VC_SHORT    = 3'd6;

    localparam logic [7:0] TAG_SSID    = 8'h00;
    localparam logic [7:0] TAG_RATES   = 8'h01;
    localparam logic [7:0] TAG_DS      = 8'h03;
    localparam logic [7:0] TAG_TIM     = 8'h05;
    localparam logic [7:0] TAG_COUNTRY = 8'h07;
    localparam logic [7:0] TAG_XRATES  = 8'h32;
    localparam logic [7:0] TAG_V80     = 8'h80;
    localparam logic [7:0] TAG_VENDOR  = 8'hdd;

    localparam logic [23:0] OUI_SRC_QUIRK = 24'h00022d;
    localparam logic [23:0] OUI_V80       = 24'h00601d;
    localparam logic [23:0] OUI_VDD       = 24'h00037f;
    localparam logic [23:0] OUI_MS        = 24'h0050f2;

    typedef struct packed {
        logic        record_kind;
        logic [3:0]  frame_kind;
        logic [47:0] source_address;
        logic [47:0] bss_address;
        logic [11:0] value_offset;
        logic [7:0]  value_length;
        logic [9:0]  highest_rate;
        logic [7:0]  channel_number;
        logic [15:0] reason_code;
        logic [7:0]  element_tag;
        logic [2:0]  vendor_class;
        logic [1:0]  parse_status;
    } t_rec;

    typedef struct packed {
        logic elem_vld;
        t_rec elem;
        logic summ_vld;
        t_rec summ;
    } t_step_out;

    function automatic t_kind kind_of(input logic [7:0] b);
        t_kind k;
        case (b)
            8'h00: k = K_ASSOC;
            8'ha0: k = K_DISASSOC;
            8'hc0: k = K_DEAUTH;
            8'h80: k = K_BEACON;
            8'h40: k = K_PROBE;
            8'h50: k = K_PROBE_RSP;
            8'h08, 8'h88: k = K_DATA;
            8'h10, 8'hd4, 8'h48, 8'hb0, 8'hb4, 8'hc4, 8'h30, 8'hc8, 8'ha4, 8'h20:
                k = K_IGNORED;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic reportable(input logic [7:0] t);
        return t inside {8'h06, 8'h0a, 8'h0b, 8'h96, 8'h2a, 8'h2f, 8'h2c, 8'h30, 8'h85};
    endfunction

    function automatic logic [2:0] vendor_class(input logic [7:0] len,
                                                input logic [31:0] sh);
        logic [23:0] oui;
        logic [7:0]  sub;
        logic [2:0]  vc;
        oui = (len >= 8'd4) ? sh[31:8] : sh[23:0];
        sub = sh[7:0];
        if (len < 8'd3) begin
            vc = VC_SHORT;
        end else begin
            case (oui)
                24'h00601d, 24'h001018, 24'h000347, 24'h004096, 24'h00037f:
                    vc = VC_KNOWN;
                OUI_MS:
                    vc = (len < 8'd4) ? VC_SHORT :
                         ((sub == 8'd1 || sub == 8'd2) ? VC_MS_CIPH : VC_MS_OTHER);
                24'h000393, 24'h000af5:
                    vc = VC_SILENT;
                default:
                    vc = VC_UNKNOWN;
            endcase
        end
        return vc;
    endfunction

endpackage

// ===== hdl/wmep_if.sv =====
// Valid/ready channel interfaces for the frame byte input and the record output.
// Depends on nothing but plain logic types.
interface wmep_in_if;
    logic        valid;
    logic        ready;
    logic        start_of_frame;
    logic [7:0]  data_byte;
    logic [11:0] frame_length;
    modport source (output valid, start_of_frame, data_byte, frame_length, input ready);
    modport sink (input valid, start_of_frame, data_byte, frame_length, output ready);
endinterface

interface wmep_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [3:0]  frame_kind;
    logic [47:0] source_address;
    logic [47:0] bss_address;
    logic [11:0] value_offset;
    logic [7:0]  value_length;
    logic [9:0]  highest_rate;
    logic [7:0]  channel_number;
    logic [15:0] reason_code;
    logic [7:0]  element_tag;
    logic [2:0]  vendor_class;
    logic [1:0]  parse_status;
    modport source (output valid, record_kind, frame_kind, source_address, bss_address,
                    value_offset, value_length, highest_rate, channel_number, reason_code,
                    element_tag, vendor_class, parse_status, input ready);
    modport sink (input valid, record_kind, frame_kind, source_address, bss_address,
                  value_offset, value_length, highest_rate, channel_number, reason_code,
                  element_tag, vendor_class, parse_status, output ready);
endinterface

// ===== hdl/wlan_mgmt_element_parser.sv =====
// Top level: input register, parser core and a small record queue on the output.
// Depends on wmep_pkg, wmep_if (wmep_in_if, wmep_out_if) and wmep_core.
//
//  channel | dir | payload                                  | items per transfer
//  i_in    | in  | start_of_frame, data_byte, frame_length  | one byte
//  o_out   | out | record_kind .. parse_status (12 fields)  | one record
//
// One byte per cycle while the queue has room: a byte is parsed while it sits in the
// input register, and its records enter a 4-entry queue at the next edge, where o_out
// can take the first record.
// A byte is parsed only when the queue can take two records, as the last byte of
// a frame can push both an element record and the summary.
// Reset (i_rst_n low, synchronous) empties the queue and clears all parser state.
// Stalls on o_out back up into i_in.ready once the queue is near full.
module wlan_mgmt_element_parser
    import wmep_pkg::*;
#(
    parameter int unsigned FRAME_MAX = C_FRAME_MAX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wmep_in_if.sink    i_in,
    wmep_out_if.source o_out
);
    localparam int unsigned QW = $clog2(C_QDEPTH);

    logic        r_iv;
    logic        r_sof;
    logic [7:0]  r_byte;
    logic [11:0] r_len;
    t_step_out   res;
    t_rec        r_q [C_QDEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    logic        pop, step;
    logic [QW:0] left;
    logic [1:0]  npush;
    t_rec        head;

    assign pop   = o_out.valid && o_out.ready;
    assign left  = r_cnt - {{QW{1'b0}}, pop};
    assign step  = r_iv && (left <= (QW+1)'(C_QDEPTH - 2));
    assign i_in.ready = !r_iv || step;
    assign npush = {1'b0, res.elem_vld} + {1'b0, res.summ_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.ready) begin
            r_iv <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_sof  <= i_in.start_of_frame;
            r_byte <= i_in.data_byte;
            r_len  <= i_in.frame_length;
        end
    end

    wmep_core #(.FRAME_MAX(FRAME_MAX)) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_sof  (r_sof),
        .i_byte (r_byte),
        .i_len  (r_len),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (res.elem_vld) begin
            r_q[r_wp] <= res.elem;
        end
        if (res.summ_vld) begin
            r_q[r_wp + QW'(res.elem_vld)] <= res.summ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QW'(npush);
            r_rp  <= r_rp + QW'(pop);
            r_cnt <= left + (QW+1)'(npush);
        end
    end

    assign head = r_q[r_rp];
    assign o_out.valid          = (r_cnt != '0);
    assign o_out.record_kind    = head.record_kind;
    assign o_out.frame_kind     = head.frame_kind;
    assign o_out.source_address = head.source_address;
    assign o_out.bss_address    = head.bss_address;
    assign o_out.value_offset   = head.value_offset;
    assign o_out.value_length   = head.value_length;
    assign o_out.highest_rate   = head.highest_rate;
    assign o_out.channel_number = head.channel_number;
    assign o_out.reason_code    = head.reason_code;
    assign o_out.element_tag    = head.element_tag;
    assign o_out.vendor_class   = head.vendor_class;
    assign o_out.parse_status   = head.parse_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QW+1)'(C_QDEPTH))
        else $error("record queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |-> npush == 2'd0)
        else $error("records produced without a parsed byte");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.elem_vld && res.summ_vld |-> res.summ.record_kind && !res.elem.record_kind)
        else $error("record order within a byte broken");
endmodule

// ===== hdl/wmep_core.sv =====
// Per-byte parser state and update: header capture, element walk, record build.
// Depends on wmep_pkg.
module wmep_core
    import wmep_pkg::*;
#(
    parameter int unsigned FRAME_MAX = C_FRAME_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_sof,
    input  logic [7:0]  i_byte,
    input  logic [11:0] i_len,
    output t_step_out   o_res
);
    localparam int unsigned LMAX = (FRAME_MAX - 1 > 4095) ? 4095 : FRAME_MAX - 1;

    logic [11:0] r_pos, n_pos;
    t_kind       r_kind, n_kind;
    logic [47:0] r_src, n_src, r_bss, n_bss;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag, r_rem, n_rem, r_elen, n_elen;
    logic [11:0] r_vstart, n_vstart;
    logic [31:0] r_oui, n_oui;
    logic [9:0]  r_rate, n_rate;
    logic [7:0]  r_chan, n_chan;
    logic [19:0] r_ssid, n_ssid;
    logic [15:0] r_reason, n_reason;
    logic [1:0]  r_status, n_status;
    logic        r_clamp, n_clamp;

    logic [11:0] lc, p, rem, idx;
    logic [12:0] p1;
    logic [4:0]  minlen;
    logic [5:0]  start;
    logic        walk_en, src_match, fin, emit;
    logic [7:0]  len;
    logic [9:0]  rate;
    logic [2:0]  vc;
    logic [23:0] want;

    always_comb begin
        n_pos = r_pos; n_kind = r_kind; n_src = r_src; n_bss = r_bss;
        n_phase = r_phase; n_tag = r_tag; n_rem = r_rem; n_elen = r_elen;
        n_vstart = r_vstart; n_oui = r_oui; n_rate = r_rate; n_chan = r_chan;
        n_ssid = r_ssid; n_reason = r_reason; n_status = r_status; n_clamp = r_clamp;
        o_res = '0;
        lc = (i_len > 12'(LMAX)) ? 12'(LMAX) : i_len;
        p = i_sof ? 12'd0 : r_pos;
        p1 = {1'b0, p} + 13'd1;
        minlen = '0; start = '0; walk_en = 1'b0; src_match = 1'b0;
        fin = 1'b0; emit = 1'b0; len = '0; rem = '0; idx = '0; rate = '0;
        vc = VC_NONE; want = '0;
        if (i_step) begin
            if (i_sof) begin
                n_pos = '0;
            end
            if (p < lc) begin
                if (p == 12'd0) begin
                    n_src = '0; n_bss = '0; n_phase = PH_TAG; n_tag = '0; n_rem = '0;
                    n_vstart = '0; n_oui = '0; n_rate = '0; n_chan = '0; n_ssid = '0;
                    n_reason = '0; n_status = ST_OK; n_elen = '0; n_clamp = 1'b0;
                    n_kind = kind_of(i_byte);
                end
                case (n_kind)
                    K_ASSOC: begin
                        minlen = 5'd28; start = 6'd28; walk_en = 1'b1;
                    end
                    K_DISASSOC, K_DEAUTH: begin
                        minlen = 5'd26;
                    end
                    K_BEACON, K_PROBE_RSP: begin
                        minlen = 5'd24; start = 6'd36; walk_en = 1'b1;
                    end
                    K_PROBE: begin
                        minlen = 5'd24; start = 6'd24; walk_en = 1'b1;
                    end
                    default: begin
                        minlen = '0;
                    end
                endcase
                if (p >= 12'd10 && p <= 12'd15) n_src = {n_src[39:0], i_byte};
                if (n_kind == K_ASSOC || n_kind == K_DISASSOC || n_kind == K_DEAUTH) begin
                    if (p >= 12'd16 && p <= 12'd21) n_bss = {n_bss[39:0], i_byte};
                    if (p == 12'd24) n_reason[7:0] = i_byte;
                    if (p == 12'd25) n_reason[15:8] = i_byte;
                end
                src_match = (n_src[47:24] == OUI_SRC_QUIRK);
                if (walk_en && lc >= 12'(minlen) && p >= 12'(start)) begin
                    case (n_phase)
                        PH_TAG: begin
                            if (p1 == {1'b0, lc} && i_byte == TAG_V80 && src_match) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_tag = i_byte;
                                if (p1 >= {1'b0, lc}) begin
                                    n_status = ST_TAG_END;
                                    n_phase = PH_STOP;
                                end else begin
                                    n_phase = PH_LEN;
                                end
                            end
                        end
                        PH_LEN: begin
                            rem = lc - p1[11:0];
                            n_vstart = p1[11:0];
                            n_clamp = 1'b0;
                            len = i_byte;
                            if ({4'd0, i_byte} > rem) begin
                                if (n_tag == TAG_TIM && src_match) begin
                                    len = rem[7:0];
                                end else if ((n_tag == TAG_V80 || n_tag == TAG_VENDOR)
                                             && rem > 12'd3) begin
                                    len = rem[7:0];
                                    n_clamp = 1'b1;
                                end else begin
                                    n_status = ST_OVERRUN;
                                    n_phase = PH_STOP;
                                end
                            end
                            if (n_phase != PH_STOP) begin
                                n_elen = len; n_rem = len; n_oui = '0;
                                if (len == 8'd0) fin = 1'b1;
                                else n_phase = PH_VAL;
                            end
                        end
                        PH_VAL: begin
                            idx = p - n_vstart;
                            if (idx < 12'd4) n_oui = {n_oui[23:0], i_byte};
                            if (n_tag == TAG_RATES || n_tag == TAG_XRATES) begin
                                rate = {1'b0, i_byte[6:0], 2'b00} + {3'd0, i_byte[6:0]};
                                if (rate > n_rate) n_rate = rate;
                            end
                            if (n_tag == TAG_DS && n_rem == 8'd1) n_chan = i_byte;
                            want = (n_tag == TAG_V80) ? OUI_V80 : OUI_VDD;
                            if (idx == 12'd2 && n_clamp && n_oui[23:0] != want) begin
                                n_status = ST_OVERRUN;
                                n_phase = PH_STOP;
                            end else begin
                                n_rem = n_rem - 8'd1;
                                if (n_rem == 8'd0) fin = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                if (fin) begin
                    n_phase = PH_TAG;
                    if (n_tag == TAG_SSID) n_ssid = {n_elen, n_vstart};
                    if (reportable(n_tag)) begin
                        emit = 1'b1;
                    end else if (n_tag == TAG_COUNTRY) begin
                        emit = (n_elen >= 8'd3);
                    end else if (n_tag == TAG_V80 || n_tag == TAG_VENDOR) begin
                        emit = 1'b1;
                        vc = vendor_class(n_elen, n_oui);
                    end
                end
                if (p1 == {1'b0, lc} && lc < 12'(minlen)) n_status = ST_SHORT;
                o_res.elem_vld = emit;
                o_res.elem = '{record_kind: 1'b0, frame_kind: n_kind, source_address: n_src,
                               bss_address: n_bss, value_offset: n_vstart,
                               value_length: n_elen, highest_rate: n_rate,
                               channel_number: n_chan, reason_code: n_reason,
                               element_tag: n_tag, vendor_class: vc,
                               parse_status: ST_OK};
                o_res.summ_vld = (p1 == {1'b0, lc});
                o_res.summ = '{record_kind: 1'b1, frame_kind: n_kind, source_address: n_src,
                               bss_address: n_bss, value_offset: n_ssid[11:0],
                               value_length: n_ssid[19:12], highest_rate: n_rate,
                               channel_number: n_chan, reason_code: n_reason,
                               element_tag: 8'd0, vendor_class: VC_NONE,
                               parse_status: n_status};
                n_pos = p1[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_kind <= K_ASSOC; r_src <= '0; r_bss <= '0;
            r_phase <= PH_TAG; r_tag <= '0; r_rem <= '0; r_elen <= '0;
            r_vstart <= '0; r_oui <= '0; r_rate <= '0; r_chan <= '0;
            r_ssid <= '0; r_reason <= '0; r_status <= ST_OK; r_clamp <= 1'b0;
        end else begin
            r_pos <= n_pos; r_kind <= n_kind; r_src <= n_src; r_bss <= n_bss;
            r_phase <= n_phase; r_tag <= n_tag; r_rem <= n_rem; r_elen <= n_elen;
            r_vstart <= n_vstart; r_oui <= n_oui; r_rate <= n_rate; r_chan <= n_chan;
            r_ssid <= n_ssid; r_reason <= n_reason; r_status <= n_status;
            r_clamp <= n_clamp;
        end
    end

    // a value byte is only ever taken while an element length is outstanding
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VAL |-> r_rem != 8'd0)
        else $error("value phase with zero remaining count");
    // clamped elements are always vendor-type tags
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VAL && r_clamp) |-> (r_tag == TAG_V80 || r_tag == TAG_VENDOR))
        else $error("clamp pending on non-vendor element");
    // an element record never carries a status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.elem_vld |-> o_res.elem.parse_status == ST_OK)
        else $error("element record with status");
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for wlan_mgmt_element_parser: byte-stream stimulus,
// a scoreboard that predicts every record, and random stalls on both channels.
// Depends on hdl/wmep_pkg.sv, hdl/wmep_if.sv and the RTL of the parser.
module tb_top
    import wmep_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    class rec_scoreboard;
        t_rec        exp_recs[$];
        int          errors;
        logic [11:0] pos;
        t_kind       kind;
        logic [47:0] src, bss;
        t_phase      phase;
        logic [7:0]  tag, rem, elen, chan, ssid_len;
        logic [11:0] vstart, ssid_off;
        logic [31:0] shift;
        logic [9:0]  rate;
        logic [15:0] reason;
        logic [1:0]  status;
        bit          clamp;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pos = 0; kind = K_ASSOC; src = 0; bss = 0; phase = PH_TAG; tag = 0;
            rem = 0; elen = 0; chan = 0; ssid_len = 0; vstart = 0; ssid_off = 0;
            shift = 0; rate = 0; reason = 0; status = ST_OK; clamp = 0;
        endfunction

        function t_kind kind_code(logic [7:0] b);
            case (b)
                8'h00: return K_ASSOC;
                8'ha0: return K_DISASSOC;
                8'hc0: return K_DEAUTH;
                8'h80: return K_BEACON;
                8'h40: return K_PROBE;
                8'h50: return K_PROBE_RSP;
                8'h08, 8'h88: return K_DATA;
                8'h10, 8'hd4, 8'h48, 8'hb0, 8'hb4, 8'hc4, 8'h30, 8'hc8, 8'ha4, 8'h20:
                    return K_IGNORED;
                default: return K_UNKNOWN;
            endcase
        endfunction

        function void emit(bit rk, logic [11:0] off, logic [7:0] len, logic [7:0] t,
                           logic [2:0] vc, logic [1:0] st);
            t_rec r;
            r.record_kind = rk;       r.frame_kind = kind;
            r.source_address = src;   r.bss_address = bss;
            r.value_offset = off;     r.value_length = len;
            r.highest_rate = rate;    r.channel_number = chan;
            r.reason_code = reason;   r.element_tag = t;
            r.vendor_class = vc;      r.parse_status = st;
            exp_recs.push_back(r);
        endfunction

        function bit src_quirk();
            return src[47:24] == OUI_SRC_QUIRK;
        endfunction

        function void close_elem();
            logic [23:0] oui;
            logic [2:0]  vc;
            bit          hit;
            phase = PH_TAG;
            if (tag == TAG_SSID) begin
                ssid_off = vstart;
                ssid_len = elen;
            end
            hit = 0;
            vc = VC_NONE;
            if (tag inside {8'h06, 8'h0a, 8'h0b, 8'h96, 8'h2a, 8'h2f, 8'h2c, 8'h30, 8'h85}) begin
                hit = 1;
            end else if (tag == TAG_COUNTRY) begin
                hit = (elen >= 3);
            end else if (tag == TAG_V80 || tag == TAG_VENDOR) begin
                hit = 1;
                if (elen < 3) begin
                    vc = VC_SHORT;
                end else begin
                    oui = (elen >= 4) ? shift[31:8] : shift[23:0];
                    case (oui)
                        24'h00601d, 24'h001018, 24'h000347, 24'h004096, 24'h00037f:
                            vc = VC_KNOWN;
                        OUI_MS:
                            vc = (elen < 4) ? VC_SHORT :
                                 ((shift[7:0] == 1 || shift[7:0] == 2) ? VC_MS_CIPH
                                                                        : VC_MS_OTHER);
                        24'h000393, 24'h000af5:
                            vc = VC_SILENT;
                        default:
                            vc = VC_UNKNOWN;
                    endcase
                end
            end
            if (hit) emit(1'b0, vstart, elen, tag, vc, ST_OK);
        endfunction

        function void walk(int p, logic [7:0] b, int lv);
            int remw, lenw, idx;
            case (phase)
                PH_TAG: begin
                    if (p + 1 == lv && b == 8'h80 && src_quirk()) begin
                        phase = PH_STOP;
                    end else begin
                        tag = b;
                        if (p + 1 >= lv) begin
                            status = ST_TAG_END;
                            phase = PH_STOP;
                        end else begin
                            phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    remw = lv - (p + 1);
                    lenw = b;
                    vstart = 12'(p + 1);
                    clamp = 0;
                    if (lenw > remw) begin
                        if (tag == TAG_TIM && src_quirk()) begin
                            lenw = remw;
                        end else if ((tag == TAG_V80 || tag == TAG_VENDOR) && remw > 3) begin
                            lenw = remw;
                            clamp = 1;
                        end else begin
                            status = ST_OVERRUN;
                            phase = PH_STOP;
                            return;
                        end
                    end
                    elen = 8'(lenw);
                    rem = 8'(lenw);
                    shift = 0;
                    if (lenw == 0) close_elem();
                    else phase = PH_VAL;
                end
                PH_VAL: begin
                    idx = (p - vstart) & 12'hfff;
                    if (idx < 4) shift = {shift[23:0], b};
                    if (tag == TAG_RATES || tag == TAG_XRATES) begin
                        if (b[6:0] * 5 > rate) rate = 10'(b[6:0] * 5);
                    end
                    if (tag == TAG_DS && rem == 1) chan = b;
                    if (idx == 2 && clamp &&
                        shift[23:0] != ((tag == TAG_V80) ? OUI_V80 : OUI_VDD)) begin
                        status = ST_OVERRUN;
                        phase = PH_STOP;
                        return;
                    end
                    rem = rem - 8'd1;
                    if (rem == 0) close_elem();
                end
                default: ;
            endcase
        endfunction

        // one accepted byte transfer
        function void note_byte(bit sof, logic [7:0] b, logic [11:0] flen);
            int p, lv, minlen, start;
            lv = flen;
            if (sof) pos = 0;
            p = pos;
            if (p >= lv) return;
            if (p == 0) begin
                clear();
                kind = kind_code(b);
            end
            minlen = 0;
            start = 65535;
            case (kind)
                K_ASSOC: begin minlen = 28; start = 28; end
                K_DISASSOC, K_DEAUTH: minlen = 26;
                K_BEACON, K_PROBE_RSP: begin minlen = 24; start = 36; end
                K_PROBE: begin minlen = 24; start = 24; end
                default: ;
            endcase
            if (p >= 10 && p <= 15) src = {src[39:0], b};
            if (kind <= K_DEAUTH) begin
                if (p >= 16 && p <= 21) bss = {bss[39:0], b};
                if (p == 24) reason[7:0] = b;
                if (p == 25) reason[15:8] = b;
            end
            if (lv >= minlen && p >= start) walk(p, b, lv);
            if (p + 1 == lv) begin
                if (lv < minlen) status = ST_SHORT;
                emit(1'b1, ssid_off, ssid_len, 8'h00, VC_NONE, status);
            end
            pos = 12'(p + 1);
        endfunction

        function void check_rec(t_rec act);
            t_rec exp_r;
            if (exp_recs.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected record %p", act);
                return;
            end
            exp_r = exp_recs.pop_front();
            if (act !== exp_r) begin
                errors++;
                if (errors <= 10) $display("record mismatch\n  exp %p\n  act %p", exp_r, act);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n;
    wmep_in_if  in_ch();
    wmep_out_if out_ch();

    wlan_mgmt_element_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    rec_scoreboard sb = new();
    bit  hold_req = 0;
    int  burst_left = 0;
    int  cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("wlan_mgmt_element_parser verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_rec r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            r.record_kind = out_ch.record_kind;       r.frame_kind = out_ch.frame_kind;
            r.source_address = out_ch.source_address; r.bss_address = out_ch.bss_address;
            r.value_offset = out_ch.value_offset;     r.value_length = out_ch.value_length;
            r.highest_rate = out_ch.highest_rate;     r.channel_number = out_ch.channel_number;
            r.reason_code = out_ch.reason_code;       r.element_tag = out_ch.element_tag;
            r.vendor_class = out_ch.vendor_class;     r.parse_status = out_ch.parse_status;
            sb.check_rec(r);
        end
    end

    // receiver: stall pattern redrawn at random among four modes; long hold-off on request
    initial begin
        int hold_left, mode, cnt;
        hold_left = 0; mode = 0; cnt = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 300;
            end
            cnt++;
            if (cnt % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= (cnt % 4 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_byte(bit sof, logic [7:0] b, logic [11:0] flen);
        in_ch.valid <= 1'b1;
        in_ch.start_of_frame <= sof;
        in_ch.data_byte <= b;
        in_ch.frame_length <= flen;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(sof, b, flen);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 30);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(logic [7:0] f[$], logic [11:0] flen, bit sof);
        foreach (f[i]) send_byte(sof && i == 0, f[i], flen);
    endtask

    // header up to the element start, with a random or quirk source address
    function automatic void make_hdr(ref logic [7:0] f[$], input logic [7:0] k,
                                     input bit quirk);
        int n;
        case (k)
            8'h00: n = 28;
            8'h80, 8'h50: n = 36;
            8'h40: n = 24;
            default: n = 26;
        endcase
        f.delete();
        f.push_back(k);
        for (int i = 1; i < n; i++) f.push_back(8'($urandom_range(0, 255)));
        if (quirk) begin
            f[10] = 8'h00; f[11] = 8'h02; f[12] = 8'h2d;
        end
    endfunction

    function automatic void rand_elem(ref logic [7:0] f[$]);
        logic [7:0] t, ln;
        logic [23:0] oui;
        int sel;
        sel = $urandom_range(0, 12);
        case (sel)
            0: t = TAG_SSID;
            1: t = TAG_RATES;
            2: t = TAG_XRATES;
            3: t = TAG_DS;
            4: t = TAG_TIM;
            5: t = TAG_COUNTRY;
            6, 7: t = TAG_VENDOR;
            8: t = TAG_V80;
            9: t = 8'h30;
            10: t = 8'h96;
            default: t = 8'($urandom_range(0, 255));
        endcase
        ln = 8'($urandom_range(0, 9));
        f.push_back(t);
        f.push_back(ln);
        case ($urandom_range(0, 5))
            0: oui = OUI_V80;
            1: oui = OUI_MS;
            2: oui = 24'h000393;
            3: oui = OUI_VDD;
            default: oui = 24'($urandom);
        endcase
        for (int i = 0; i < ln; i++) begin
            if ((t == TAG_VENDOR || t == TAG_V80) && i < 3) f.push_back(oui[23 - 8*i -: 8]);
            else if (i == 3 && $urandom_range(0, 1)) f.push_back(8'($urandom_range(1, 3)));
            else f.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin
        logic [7:0] f[$];
        logic [7:0] kinds[$];
        int total, mode, nel;
        bit held, paused;
        logic [11:0] flen;
        kinds = {8'h00, 8'ha0, 8'hc0, 8'h80, 8'h40, 8'h50, 8'h08, 8'h10, 8'h80, 8'h50};
        in_ch.valid <= 1'b0;
        in_ch.start_of_frame <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.frame_length <= 12'd0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // deauth sent without a start mark: first byte after reset is byte 0
        make_hdr(f, 8'hc0, 0);
        send_frame(f, 12'(f.size()), 0);
        // beacon with rates, DS, country, SSID, RSN and vendor elements of each vendor class
        make_hdr(f, 8'h80, 0);
        f = {f, 8'h00, 8'h00, 8'h01, 8'h02, 8'hff, 8'h82, 8'h03, 8'h01, 8'h06,
             8'h07, 8'h02, 8'h41, 8'h42, 8'h07, 8'h03, 8'h41, 8'h42, 8'h43,
             8'hdd, 8'h04, 8'h00, 8'h50, 8'hf2, 8'h01, 8'hdd, 8'h04, 8'h00, 8'h50,
             8'hf2, 8'h07, 8'hdd, 8'h03, 8'h00, 8'h50, 8'hf2, 8'hdd, 8'h02, 8'h00,
             8'h01, 8'h80, 8'h04, 8'h00, 8'h60, 8'h1d, 8'h00, 8'hdd, 8'h03, 8'h00,
             8'h03, 8'h93, 8'hdd, 8'h03, 8'h11, 8'h22, 8'h33, 8'h30, 8'h02, 8'h01,
             8'h00, 8'h00, 8'h03, 8'h41, 8'h42, 8'h43};
        send_frame(f, 12'(f.size()), 1);
        // TIM overrun from the quirk source, then lone 0x80 at the end
        make_hdr(f, 8'h50, 1);
        f = {f, TAG_TIM, 8'd50, 8'h01, 8'h02};
        send_frame(f, 12'(f.size()), 1);
        make_hdr(f, 8'h80, 1);
        f = {f, 8'h80};
        send_frame(f, 12'(f.size()), 1);
        // tag on the last byte
        make_hdr(f, 8'h40, 0);
        f = {f, 8'h2a};
        send_frame(f, 12'(f.size()), 1);
        // short association frame
        make_hdr(f, 8'h00, 0);
        send_frame(f[0:19], 12'd20, 1);
        // vendor overruns: good OUI clamped, wrong OUI stops
        make_hdr(f, 8'h80, 0);
        f = {f, 8'h80, 8'd40, 8'h00, 8'h60, 8'h1d, 8'h05, 8'h06};
        send_frame(f, 12'(f.size()), 1);
        make_hdr(f, 8'h80, 0);
        f = {f, 8'hdd, 8'd40, 8'h00, 8'h60, 8'h1d, 8'h05, 8'h06};
        send_frame(f, 12'(f.size()), 1);
        // zero length frame, then stray bytes past the end
        send_byte(1, 8'h80, 12'd0);
        send_byte(1, 8'h80, 12'd2);
        send_byte(0, 8'h12, 12'd2);
        send_byte(0, 8'h34, 12'd2);
        // long frame cut off by the next start mark
        make_hdr(f, 8'h80, 0);
        send_frame(f[0:5], 12'hfff, 1);

        total = 0;
        held = 0;
        paused = 0;
        while (total < 460) begin
            if (!held && total > 120) begin
                hold_req = 1;
                held = 1;
            end
            if (!paused && total > 300) begin
                paused = 1;
                in_ch.valid <= 1'b0;
                while (sb.exp_recs.size() != 0) @(posedge i_clk);
            end
            make_hdr(f, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                     kinds[$urandom_range(0, kinds.size() - 1)], $urandom_range(0, 2) == 0);
            nel = $urandom_range(0, 6);
            repeat (nel) rand_elem(f);
            mode = $urandom_range(0, 9);
            flen = 12'(f.size());
            if (mode == 0 && f.size() > 30) begin
                flen = 12'(f.size() - $urandom_range(1, 3));
            end else if (mode == 1) begin
                f.push_back(($urandom_range(0, 1) != 0) ? 8'h80 : 8'($urandom_range(0, 255)));
                flen = 12'(f.size());
            end else if (mode == 2) begin
                flen = 12'($urandom_range(1, 27));
            end
            for (int i = 0; i < f.size() && i < flen; i++) send_byte(i == 0, f[i], flen);
            total += (flen < f.size()) ? int'(flen) : f.size();
        end
        in_ch.valid <= 1'b0;
        while (sb.exp_recs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_recs.size() == 0) begin
            $display("wlan_mgmt_element_parser verification clean");
        end else begin
            $display("wlan_mgmt_element_parser verification failed");
        end
        $finish;
    end
endmodule
